FILE: hw/rtl/csma_pkg.sv
// Shared types and constants for the carrier-sense backoff controller.
package csma_pkg;

  // Configuration port geometry: three 32-bit registers at byte addresses 0, 4 and 8.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [9:0]  RSSI_FLOOR_RST    = 10'd300;
  localparam logic [3:0]  CCA_SAMPLES_RST   = 4'd6;
  localparam logic [15:0] FIRST_BACKOFF_RST = 16'd12;

  // The initial backoff is (random mod START_WAIT_MOD) + 1 ms. The residue logic
  // folds octal digits, which relies on 8 mod 7 being 1, so this value is fixed.
  localparam logic [3:0] START_WAIT_MOD = 4'd7;

  // Upper limit of any congestion backoff.
  localparam logic [15:0] BACKOFF_CAP = 16'd32768;
  localparam logic [15:0] BACKOFF_HALF_CAP = 16'd16384;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_TICK = 2'd1,
    KIND_RSSI = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_BUSY       = 3'd2,
    ST_INIT_BO    = 3'd3,
    ST_CONGEST_BO = 3'd4,
    ST_SENSING    = 3'd5,
    ST_TRANSMIT   = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] random_value;
    logic [7:0]  packet_size;
    logic [9:0]  rssi_level;
    logic        radio_idle;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] backoff_ms;
    logic        busy_res;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  rssi_floor;
    logic [3:0]  cca_sample_count;
    logic [15:0] first_congestion_backoff;
  } cfg_t;

endpackage

FILE: hw/rtl/csma_cfg_regs.sv
// APB-style configuration registers of the carrier-sense backoff controller.
module csma_cfg_regs
  import csma_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  localparam logic [1:0] REG_RSSI_FLOOR    = 2'd0;
  localparam logic [1:0] REG_CCA_SAMPLES   = 2'd1;
  localparam logic [1:0] REG_FIRST_BACKOFF = 2'd2;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rssi_floor               <= RSSI_FLOOR_RST;
      cfg_q.cca_sample_count         <= CCA_SAMPLES_RST;
      cfg_q.first_congestion_backoff <= FIRST_BACKOFF_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RSSI_FLOOR:    cfg_q.rssi_floor               <= pwdata[9:0];
        REG_CCA_SAMPLES:   cfg_q.cca_sample_count         <= pwdata[3:0];
        REG_FIRST_BACKOFF: cfg_q.first_congestion_backoff <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_RSSI_FLOOR:    prdata = {22'd0, cfg_q.rssi_floor};
      REG_CCA_SAMPLES:   prdata = {28'd0, cfg_q.cca_sample_count};
      REG_FIRST_BACKOFF: prdata = {16'd0, cfg_q.first_congestion_backoff};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/csma_core.sv
// Input register, send-state update and result register of the backoff controller.
module csma_core
  import csma_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_BACKOFF = 2'd1,
    PH_SENSING = 2'd2
  } phase_e;

  function automatic logic [15:0] clamp_backoff(input logic [15:0] v);
    logic [15:0] r;
    if (v == 16'd0) begin
      r = 16'd1;
    end else if (v > BACKOFF_CAP) begin
      r = BACKOFF_CAP;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Pipeline control
  logic      item_valid_q;
  in_item_t  item_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      in_take;
  logic      advance;
  logic      step_en;

  // Send state
  phase_e      phase_q, phase_d;
  logic [15:0] remaining_q, remaining_d;
  logic [15:0] next_cong_q, next_cong_d;
  logic [3:0]  clear_cnt_q, clear_cnt_d;
  out_item_t   res;

  // Residue of the random value modulo seven, by summing its octal digits.
  logic [5:0]  dig_sum;
  logic [3:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  rnd_mod;
  logic [15:0] start_wait;

  logic [15:0] cur_backoff;
  logic [15:0] dbl_backoff;
  logic        sample_good;
  logic [3:0]  clear_inc;

  assign advance    = ~out_valid_q | ~out_stall_i;
  assign step_en    = item_valid_q & advance;
  assign in_stall_o = item_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    dig_sum = {3'd0, item_q.random_value[2:0]}   + {3'd0, item_q.random_value[5:3]}
            + {3'd0, item_q.random_value[8:6]}   + {3'd0, item_q.random_value[11:9]}
            + {3'd0, item_q.random_value[14:12]} + {5'd0, item_q.random_value[15]};
    fold1   = {1'b0, dig_sum[5:3]} + {1'b0, dig_sum[2:0]};
    fold2   = {3'd0, fold1[3]} + {1'b0, fold1[2:0]};
    rnd_mod = (fold2 == START_WAIT_MOD) ? 3'd0 : fold2[2:0];
    start_wait = {13'd0, rnd_mod} + 16'd1;
  end

  assign cur_backoff = clamp_backoff(next_cong_q);
  assign dbl_backoff = (cur_backoff > BACKOFF_HALF_CAP) ? BACKOFF_CAP
                                                        : {cur_backoff[14:0], 1'b0};
  assign sample_good = item_q.radio_idle & (item_q.rssi_level >= cfg_i.rssi_floor);
  assign clear_inc   = clear_cnt_q + 4'd1;

  always_comb begin
    phase_d        = phase_q;
    remaining_d    = remaining_q;
    next_cong_d    = next_cong_q;
    clear_cnt_d    = clear_cnt_q;
    res.status     = ST_NONE;
    res.backoff_ms = 16'd0;
    case (item_q.kind)
      KIND_SEND: begin
        if (item_q.packet_size == 8'd0) begin
          res.status = ST_EMPTY;
        end else if (phase_q != PH_IDLE) begin
          res.status = ST_BUSY;
        end else begin
          remaining_d    = start_wait;
          next_cong_d    = clamp_backoff(cfg_i.first_congestion_backoff);
          clear_cnt_d    = 4'd0;
          phase_d        = PH_BACKOFF;
          res.status     = ST_INIT_BO;
          res.backoff_ms = start_wait;
        end
      end
      KIND_TICK: begin
        if (phase_q == PH_BACKOFF) begin
          if (remaining_q <= 16'd1) begin
            remaining_d = 16'd0;
            clear_cnt_d = 4'd0;
            phase_d     = PH_SENSING;
            res.status  = ST_SENSING;
          end else begin
            remaining_d = remaining_q - 16'd1;
          end
        end
      end
      KIND_RSSI: begin
        if (phase_q == PH_SENSING) begin
          if (sample_good) begin
            // A sample count of zero is met by the very first good sample.
            if (clear_inc >= cfg_i.cca_sample_count) begin
              clear_cnt_d = 4'd0;
              phase_d     = PH_IDLE;
              res.status  = ST_TRANSMIT;
            end else begin
              clear_cnt_d = clear_inc;
            end
          end else begin
            remaining_d    = cur_backoff;
            next_cong_d    = dbl_backoff;
            clear_cnt_d    = 4'd0;
            phase_d        = PH_BACKOFF;
            res.status     = ST_CONGEST_BO;
            res.backoff_ms = cur_backoff;
          end
        end
      end
      default: ;
    endcase
    res.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_IDLE;
      remaining_q  <= 16'd0;
      next_cong_q  <= 16'd0;
      clear_cnt_q  <= 4'd0;
    end else begin
      if (in_take) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (step_en) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        remaining_q <= remaining_d;
        next_cong_q <= next_cong_d;
        clear_cnt_q <= clear_cnt_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
    if (step_en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/csma_backoff_controller_top.sv
// Top level of the carrier-sense send controller with exponential congestion backoff.
//
// Events (send request, millisecond tick, rssi sample) enter on the input channel
// (in_valid_i / in_stall_o / in_data_i). Every accepted event yields exactly one
// result on the output channel (out_valid_o / out_stall_i / out_data_o) carrying
// the status code, the backoff just armed and the busy flag.
// An event is captured in the input register at its transfer; the state update and
// result are computed from that register and land in the result register. One event
// per cycle is sustained while the receiver does not stall: the combinational update
// between the two registers sets that rate. When the receiver stalls, the result
// register holds its item; the input register still takes one more event, and
// in_stall_o rises only when both registers are full. Reset clears both registers and
// returns the controller to idle with no backoff armed; the configuration registers
// return to floor 300, six clear samples and a first congestion backoff of 12 ms.
// The user must write the APB port only while idle; the block does not enforce it.
module csma_backoff_controller_top
  import csma_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  cfg_t cfg;

  csma_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csma_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
